### hdl/irmsp_pkg.sv
// package for the ir mark/space player
// widths, codes and the controller/datapath command and status types
// no dependencies
package irmsp_pkg;

    localparam int DEPTH   = 512;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int POS_W   = $clog2(DEPTH + 1);
    localparam int DUR_W   = 16;
    localparam int ENTRY_W = 10;
    localparam int KIND_W  = 2;
    localparam int MODE_W  = 2;
    localparam int S_DATA_W = 2 * DUR_W;
    localparam int M_DATA_W = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_INIT = 2'd0,
        KIND_LOAD = 2'd1,
        KIND_TICK = 2'd2,
        KIND_STOP = 2'd3
    } kind_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF  = 2'd0,
        MODE_INIT = 2'd1,
        MODE_IDLE = 2'd2,
        MODE_SEND = 2'd3
    } mode_t;

    // result word layout
    localparam int CARRIER_BIT = 0;
    localparam int MODE_LSB    = 1;
    localparam int DROP_BIT    = MODE_LSB + MODE_W;
    localparam int ENTRY_LSB   = DROP_BIT + 1;

    typedef struct packed {
        logic step;   // input word accepted this cycle
        logic fetch;  // read the entry at the play position
    } irmsp_cmd_t;

    typedef struct packed {
        logic need_fetch;  // current word moves playback to a new entry
    } irmsp_sts_t;

endpackage

### hdl/irmsp_ctrl.sv
// controller for the ir mark/space player
// handshake on both channels and the entry fetch sequence; uses irmsp_pkg
module irmsp_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  irmsp_pkg::irmsp_sts_t sts,
    output irmsp_pkg::irmsp_cmd_t cmd
);
    import irmsp_pkg::*;

    typedef enum logic {
        ST_RUN,
        ST_FETCH
    } state_t;

    state_t state_reg;
    logic   m_tvalid_reg;

    assign s_tready  = (state_reg == ST_RUN) && (!m_tvalid_reg || m_tready);
    assign m_tvalid  = m_tvalid_reg;
    assign cmd.step  = s_tvalid && s_tready;
    assign cmd.fetch = (state_reg == ST_FETCH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_RUN;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.step) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_RUN: begin
                    if (cmd.step && sts.need_fetch) begin
                        state_reg <= ST_FETCH;
                    end
                end
                ST_FETCH: begin
                    state_reg <= ST_RUN;
                end
                default: begin
                    state_reg <= ST_RUN;
                end
            endcase
        end
    end

endmodule

### hdl/irmsp_dp.sv
// datapath for the ir mark/space player
// entry store, play/load positions, segment timer and result register; uses irmsp_pkg
module irmsp_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  irmsp_pkg::irmsp_cmd_t               cmd,
    output irmsp_pkg::irmsp_sts_t               sts,
    input  logic [irmsp_pkg::KIND_W-1:0]        s_tuser,
    input  logic [irmsp_pkg::S_DATA_W-1:0]      s_tdata,
    input  logic                                s_tlast,
    output logic [irmsp_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                                m_tlast
);
    import irmsp_pkg::*;

    // store word: mark in the low half, space in the high half
    logic [S_DATA_W-1:0] mem [DEPTH];
    logic [S_DATA_W-1:0] rdata_reg;

    logic [POS_W-1:0] frame_len_reg,  frame_len_next;
    logic [POS_W-1:0] play_pos_reg,   play_pos_next;
    logic [POS_W-1:0] load_pos_reg,   load_pos_next;
    logic [DUR_W-1:0] elapsed_reg,    elapsed_next;
    logic             in_mark_reg,    in_mark_next;
    mode_t            mode_reg,       mode_next;

    logic [M_DATA_W-1:0] m_tdata_reg;
    logic                m_tlast_reg;
    logic [M_DATA_W-1:0] result_word;

    kind_t            kind;
    logic             fits;
    logic             wr_en;
    logic             carrier;
    logic             done;
    logic             dropped;
    logic             fetch_req;
    logic [POS_W-1:0] load_inc;
    logic [DUR_W-1:0] elapsed_inc;
    logic [DUR_W-1:0] dur;

    assign kind        = kind_t'(s_tuser);
    assign fits        = (load_pos_reg < POS_W'(DEPTH));
    assign load_inc    = load_pos_reg + POS_W'(1);
    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + DUR_W'(1);
    assign dur         = in_mark_reg ? rdata_reg[DUR_W-1:0] : rdata_reg[S_DATA_W-1:DUR_W];

    always_comb begin
        frame_len_next = frame_len_reg;
        play_pos_next  = play_pos_reg;
        load_pos_next  = load_pos_reg;
        elapsed_next   = elapsed_reg;
        in_mark_next   = in_mark_reg;
        mode_next      = mode_reg;
        carrier        = 1'b0;
        done           = 1'b0;
        dropped        = 1'b0;
        wr_en          = 1'b0;
        fetch_req      = 1'b0;
        case (kind)
            KIND_INIT: begin
                if (mode_reg == MODE_OFF) begin
                    mode_next = MODE_INIT;
                end
            end
            KIND_LOAD: begin
                if (fits) begin
                    wr_en         = 1'b1;
                    load_pos_next = load_inc;
                end else begin
                    dropped = 1'b1;
                end
                if (s_tlast) begin
                    frame_len_next = fits ? load_inc : load_pos_reg;
                    load_pos_next  = '0;
                    play_pos_next  = '0;
                    in_mark_next   = 1'b1;
                    elapsed_next   = '0;
                    mode_next      = MODE_SEND;
                    fetch_req      = 1'b1;
                end else if (mode_reg == MODE_SEND) begin
                    mode_next = MODE_IDLE;
                end
            end
            KIND_TICK: begin
                if (mode_reg == MODE_SEND) begin
                    if (play_pos_reg >= frame_len_reg || play_pos_reg >= POS_W'(DEPTH)) begin
                        mode_next = MODE_IDLE;
                        done      = 1'b1;
                    end else begin
                        carrier      = in_mark_reg;
                        elapsed_next = elapsed_inc;
                        if (elapsed_inc >= dur) begin
                            elapsed_next = '0;
                            in_mark_next = !in_mark_reg;
                            // end of space moves on to the next entry
                            if (!in_mark_reg) begin
                                play_pos_next = play_pos_reg + POS_W'(1);
                                fetch_req     = 1'b1;
                            end
                        end
                    end
                end
            end
            KIND_STOP: begin
                mode_next = MODE_OFF;
            end
            default: begin
                mode_next = mode_reg;
            end
        endcase
    end

    assign sts.need_fetch = fetch_req;

    always_comb begin
        result_word                        = '0;
        result_word[CARRIER_BIT]           = carrier;
        result_word[MODE_LSB +: MODE_W]    = mode_next;
        result_word[DROP_BIT]              = dropped;
        result_word[ENTRY_LSB +: ENTRY_W]  = ENTRY_W'(play_pos_next);
    end

    always_ff @(posedge aclk) begin
        if (wr_en && cmd.step) begin
            mem[load_pos_reg[ADDR_W-1:0]] <= s_tdata;
        end
        if (cmd.fetch) begin
            rdata_reg <= mem[play_pos_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_len_reg <= '0;
            play_pos_reg  <= '0;
            load_pos_reg  <= '0;
            elapsed_reg   <= '0;
            in_mark_reg   <= 1'b0;
            mode_reg      <= MODE_OFF;
        end else if (cmd.step) begin
            frame_len_reg <= frame_len_next;
            play_pos_reg  <= play_pos_next;
            load_pos_reg  <= load_pos_next;
            elapsed_reg   <= elapsed_next;
            in_mark_reg   <= in_mark_next;
            mode_reg      <= mode_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step) begin
            m_tdata_reg <= result_word;
            m_tlast_reg <= done;
        end
    end

    assign m_tdata = m_tdata_reg;
    assign m_tlast = m_tlast_reg;

endmodule

### hdl/ir_mark_space_player.sv
// ir mark/space player top level: controller plus datapath; uses irmsp_pkg
// latency: a result word is presented the cycle after its input word is taken
// throughput: one word per cycle unless stalled; a word that starts playback or
// moves to the next entry is followed by an entry store read taking no input
// reset clears mode, positions, timer and handshake state; the entry store
// is not cleared and holds garbage until loaded
module ir_mark_space_player (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [irmsp_pkg::S_DATA_W-1:0]       s_tdata,   // mark_us, space_us
    input  logic [irmsp_pkg::KIND_W-1:0]         s_tuser,   // kind
    input  logic                                 s_tlast,   // last_entry
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // carrier_enable, tx_mode, load_dropped, entry_index, zero pad
    output logic [irmsp_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                                 m_tlast    // frame_done
);
    import irmsp_pkg::*;

    irmsp_cmd_t cmd;
    irmsp_sts_t sts;

    irmsp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    irmsp_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .s_tuser (s_tuser),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

endmodule

### hdl/irmsp_checker.sv
// port-level checks for the ir mark/space player
// bound to ir_mark_space_player; uses irmsp_pkg
module irmsp_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_tvalid,
    input logic                                 s_tready,
    input logic [irmsp_pkg::KIND_W-1:0]         s_tuser,
    input logic                                 s_tlast,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [irmsp_pkg::M_DATA_W-1:0]       m_tdata,
    input logic                                 m_tlast
);
    import irmsp_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // starting playback is followed by an entry store read that takes no input
    a_start_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == KIND_LOAD) && s_tlast |=> !s_tready)
        else $error("input taken during entry fetch");

    // frame done leaves the player idle
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[MODE_LSB +: MODE_W] == MODE_IDLE)
        else $error("frame done without idle mode");

    // carrier only ever gated on while sending
    a_carrier_send: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[CARRIER_BIT] |-> m_tdata[MODE_LSB +: MODE_W] == MODE_SEND
            && !m_tlast && !m_tdata[DROP_BIT])
        else $error("carrier on outside playback");

endmodule

bind ir_mark_space_player irmsp_checker u_irmsp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
